FILE: hw/rtl/pta_pkg.sv
`timescale 1ns / 1ps

package pta_pkg;

    // request codes carried in req_type
    localparam logic [1:0] REQ_INTERNAL = 2'd0;
    localparam logic [1:0] REQ_EXTERNAL = 2'd1;
    localparam logic [1:0] REQ_CLEAR    = 2'd2;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd6;

    // microseconds per second, and twice that for the trapezoid halving
    localparam int US_PER_S     = 1000000;
    localparam int TWO_US_PER_S = 2000000;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_NEXT = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    // which quantity the shared serial unit is working on
    typedef enum logic [4:0] {
        PH_INC = 5'b00001,
        PH_DER = 5'b00010,
        PH_P   = 5'b00100,
        PH_I   = 5'b01000,
        PH_D   = 5'b10000
    } phase_t;

endpackage

FILE: hw/rtl/pid_trapezoid_antiwindup.sv
`timescale 1ns / 1ps

// PID controller step in signed fixed point (Q16.16 by default) with trapezoidal
// integration, a symmetric integral clamp and an output clamp. One word is handled at a
// time by a bit-serial sequencer: a shift-add multiplier (width BW = max(DATA_WIDTH,
// TIME_WIDTH, 21)), shared by all terms, and a restoring divider (width PW =
// DATA_WIDTH+1+BW), used for the integral increment and the derivative. With elapsed_us
// zero the derivative pass is skipped. A clear or unused request goes straight to the
// output stage. The next word is accepted as soon as the sequencer is back in idle,
// while the result may still wait in the output register.
module pid_trapezoid_antiwindup #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int TIME_WIDTH = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [pta_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_WIDTH-1:0]         cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [DATA_WIDTH-1:0]         s_feedback,
    input  logic [DATA_WIDTH-1:0]         s_feedback_rate,
    input  logic [TIME_WIDTH-1:0]         s_elapsed_us,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [DATA_WIDTH-1:0]         m_control_out,
    output logic                          m_output_clamped,
    output logic                          m_integral_clamped,
    output logic                          m_zero_interval
);
    import pta_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int AW   = DW + 1;
    localparam int BW0  = (DW > TIME_WIDTH) ? DW : TIME_WIDTH;
    localparam int BW   = (BW0 > 21) ? BW0 : 21;
    localparam int PW   = AW + BW;
    localparam int SUMW = PW + 1;
    localparam int CW   = $clog2(PW + 1);

    // configuration
    logic [DW-1:0] sp_reg, gp_reg, gi_reg, gd_reg, omax_reg, omin_reg;
    logic [DW-1:0] sp_next, gp_next, gi_next, gd_next, omax_next, omin_next;
    logic [DW-2:0] lim_reg, lim_next;

    // controller history
    logic [DW-1:0] prev_err_reg, isum_reg, prev_sp_reg;
    logic [DW-1:0] prev_err_next, isum_next, prev_sp_next;

    // sequencer
    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [1:0]      req_reg, req_next;
    logic [DW-1:0]   fbr_reg, fbr_next;
    logic [TIME_WIDTH-1:0] dt_reg, dt_next;
    logic            zero_reg, zero_next;
    logic [DW-1:0]   err_reg, err_next;
    logic [DW-1:0]   integ_reg, integ_next;
    logic [DW-1:0]   deriv_reg, deriv_next;
    logic            iclamp_reg, iclamp_next;
    logic            neg_reg, neg_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   ma_reg, ma_next;
    logic [AW-1:0]   mhi_reg, mhi_next;
    logic [BW-1:0]   mlo_reg, mlo_next;
    logic [PW-1:0]   num_reg, num_next;
    logic [BW-1:0]   rem_reg, rem_next;
    logic [BW-1:0]   den_reg, den_next;
    logic [SUMW-1:0] sum_reg, sum_next;

    // output register
    logic            m_valid_reg, m_valid_next;
    logic [DW-1:0]   m_out_reg, m_out_next;
    logic            m_oc_reg, m_oc_next, m_ic_reg, m_ic_next, m_zi_reg, m_zi_next;

    // error, saturated
    logic [DW:0]   ediff;
    logic [DW-1:0] err_sat;
    assign ediff   = {sp_reg[DW-1], sp_reg} - {s_feedback[DW-1], s_feedback};
    assign err_sat = (ediff[DW] != ediff[DW-1]) ? {ediff[DW], {(DW-1){~ediff[DW]}}}
                                                : ediff[DW-1:0];

    // error sum for the trapezoid and its magnitude
    logic [AW-1:0] esum, esum_mag;
    assign esum     = {err_sat[DW-1], err_sat} + {prev_err_reg[DW-1], prev_err_reg};
    assign esum_mag = esum[AW-1] ? (~esum + AW'(1)) : esum;

    // difference for the derivative
    logic [AW-1:0] ddiff, ddiff_mag;
    assign ddiff = (req_reg == REQ_INTERNAL)
                   ? ({err_reg[DW-1], err_reg} - {prev_err_reg[DW-1], prev_err_reg})
                   : ({sp_reg[DW-1], sp_reg} - {prev_sp_reg[DW-1], prev_sp_reg});
    assign ddiff_mag = ddiff[AW-1] ? (~ddiff + AW'(1)) : ddiff;

    // multiplier step: add on the high half, shift right
    logic [AW:0] msum;
    assign msum = {1'b0, mhi_reg} + (mlo_reg[0] ? {1'b0, ma_reg} : {(AW+1){1'b0}});

    // divider step: restoring, one quotient bit per cycle
    logic [BW:0] trial, tdiff;
    logic        tge;
    assign trial = {rem_reg, num_reg[PW-1]};
    assign tdiff = trial - {1'b0, den_reg};
    assign tge   = (trial >= {1'b0, den_reg});

    // signed quotient and signed product
    logic [PW:0] qs, ps;
    assign qs = neg_reg ? (~{1'b0, num_reg} + (PW+1)'(1)) : {1'b0, num_reg};
    assign ps = neg_reg ? (~{1'b0, mhi_reg, mlo_reg} + (PW+1)'(1))
                        : {1'b0, mhi_reg, mlo_reg};

    // integral update and clamp
    logic [PW+1:0] integ_w, lim_w, nlim_w;
    logic          igt, ilt;
    assign integ_w = {{(PW+2-DW){isum_reg[DW-1]}}, isum_reg} + {qs[PW], qs};
    assign lim_w   = {{(PW+3-DW){1'b0}}, lim_reg};
    assign nlim_w  = ~lim_w + (PW+2)'(1);
    assign igt     = $signed(integ_w) > $signed(lim_w);
    assign ilt     = $signed(integ_w) < $signed(nlim_w);

    // rate quotient saturated, and the external derivative
    logic          q_ok;
    logic [DW-1:0] qsat, ext_sat;
    logic [DW:0]   edr;
    assign q_ok    = (&qs[PW:DW-1]) || ~(|qs[PW:DW-1]);
    assign qsat    = q_ok ? qs[DW-1:0] : {qs[PW], {(DW-1){~qs[PW]}}};
    assign edr     = {qsat[DW-1], qsat} - {fbr_reg[DW-1], fbr_reg};
    assign ext_sat = (edr[DW] != edr[DW-1]) ? {edr[DW], {(DW-1){~edr[DW]}}} : edr[DW-1:0];

    // magnitudes of the gains and terms
    logic [DW-1:0] gi_mag, gd_mag, gp_mag, err_mag, integ_mag, deriv_mag;
    assign gp_mag    = gp_reg[DW-1]    ? (~gp_reg + DW'(1))    : gp_reg;
    assign gi_mag    = gi_reg[DW-1]    ? (~gi_reg + DW'(1))    : gi_reg;
    assign gd_mag    = gd_reg[DW-1]    ? (~gd_reg + DW'(1))    : gd_reg;
    assign err_mag   = err_reg[DW-1]   ? (~err_reg + DW'(1))   : err_reg;
    assign integ_mag = integ_reg[DW-1] ? (~integ_reg + DW'(1)) : integ_reg;
    assign deriv_mag = deriv_reg[DW-1] ? (~deriv_reg + DW'(1)) : deriv_reg;

    // final scaling and output clamp
    logic [SUMW-1:0] sum_sh, omax_w, omin_w;
    logic            ogt, olt;
    assign sum_sh = $signed(sum_reg) >>> FRAC_BITS;
    assign omax_w = {{(SUMW-DW){omax_reg[DW-1]}}, omax_reg};
    assign omin_w = {{(SUMW-DW){omin_reg[DW-1]}}, omin_reg};
    assign ogt    = $signed(sum_sh) > $signed(omax_w);
    assign olt    = $signed(sum_sh) < $signed(omin_w);

    logic is_step;
    assign is_step = (req_reg == REQ_INTERNAL) || (req_reg == REQ_EXTERNAL);

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_control_out      = m_out_reg;
    assign m_output_clamped   = m_oc_reg;
    assign m_integral_clamped = m_ic_reg;
    assign m_zero_interval    = m_zi_reg;

    // next-state logic
    always_comb begin
        sp_next = sp_reg;   gp_next = gp_reg;     gi_next = gi_reg;   gd_next = gd_reg;
        omax_next = omax_reg; omin_next = omin_reg; lim_next = lim_reg;
        prev_err_next = prev_err_reg; isum_next = isum_reg; prev_sp_next = prev_sp_reg;
        state_next = state_reg; phase_next = phase_reg; req_next = req_reg;
        fbr_next = fbr_reg; dt_next = dt_reg; zero_next = zero_reg; err_next = err_reg;
        integ_next = integ_reg; deriv_next = deriv_reg; iclamp_next = iclamp_reg;
        neg_next = neg_reg; cnt_next = cnt_reg; ma_next = ma_reg; mhi_next = mhi_reg;
        mlo_next = mlo_reg; num_next = num_reg; rem_next = rem_reg; den_next = den_reg;
        sum_next = sum_reg;
        m_valid_next = m_valid_reg; m_out_next = m_out_reg;
        m_oc_next = m_oc_reg; m_ic_next = m_ic_reg; m_zi_next = m_zi_reg;

        // configuration writes
        if (cfg_we) begin
            case (cfg_index)
                CFG_SETPOINT:  sp_next   = cfg_data;
                CFG_GAIN_P:    gp_next   = cfg_data;
                CFG_GAIN_I:    gi_next   = cfg_data;
                CFG_GAIN_D:    gd_next   = cfg_data;
                CFG_OUT_MAX:   omax_next = cfg_data;
                CFG_OUT_MIN:   omin_next = cfg_data;
                CFG_INT_LIMIT: lim_next  = cfg_data[DW-2:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next  = s_req_type;
                    fbr_next  = s_feedback_rate;
                    dt_next   = s_elapsed_us;
                    zero_next = (s_elapsed_us == '0);
                    if (s_req_type == REQ_CLEAR) begin
                        prev_err_next = '0;
                        isum_next     = '0;
                        prev_sp_next  = '0;
                        state_next    = ST_DONE;
                    end else if (s_req_type == REQ_UNUSED) begin
                        state_next = ST_DONE;
                    end else begin
                        // increment: |e + e_prev| * dt
                        err_next   = err_sat;
                        neg_next   = esum[AW-1];
                        ma_next    = esum_mag;
                        mhi_next   = '0;
                        mlo_next   = BW'(s_elapsed_us);
                        cnt_next   = '0;
                        phase_next = PH_INC;
                        state_next = ST_MUL;
                    end
                end
            end

            ST_MUL: begin
                mhi_next = msum[AW:1];
                mlo_next = {msum[0], mlo_reg[BW-1:1]};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(BW - 1)) begin
                    cnt_next = '0;
                    if (phase_reg == PH_INC || phase_reg == PH_DER) begin
                        num_next   = {msum[AW:1], msum[0], mlo_reg[BW-1:1]};
                        rem_next   = '0;
                        den_next   = (phase_reg == PH_INC) ? BW'(TWO_US_PER_S)
                                                           : BW'(dt_reg);
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_NEXT;
                    end
                end
            end

            ST_DIV: begin
                rem_next = tge ? tdiff[BW-1:0] : trial[BW-1:0];
                num_next = {num_reg[PW-2:0], tge};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(PW - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_NEXT;
                end
            end

            ST_NEXT: begin
                mhi_next = '0;
                cnt_next = '0;
                state_next = ST_MUL;
                case (phase_reg)
                    PH_INC: begin
                        iclamp_next = igt || ilt;
                        integ_next  = igt ? {1'b0, lim_reg}
                                    : ilt ? (~{1'b0, lim_reg} + DW'(1))
                                    : integ_w[DW-1:0];
                        if (zero_reg) begin
                            deriv_next = '0;
                            ma_next    = {1'b0, gp_mag};
                            mlo_next   = BW'(err_mag);
                            neg_next   = gp_reg[DW-1] ^ err_reg[DW-1];
                            sum_next   = '0;
                            phase_next = PH_P;
                        end else begin
                            ma_next    = ddiff_mag;
                            mlo_next   = BW'(US_PER_S);
                            neg_next   = ddiff[AW-1];
                            phase_next = PH_DER;
                        end
                    end
                    PH_DER: begin
                        deriv_next = (req_reg == REQ_INTERNAL) ? qsat : ext_sat;
                        ma_next    = {1'b0, gp_mag};
                        mlo_next   = BW'(err_mag);
                        neg_next   = gp_reg[DW-1] ^ err_reg[DW-1];
                        sum_next   = '0;
                        phase_next = PH_P;
                    end
                    PH_P: begin
                        sum_next   = sum_reg + ps;
                        ma_next    = {1'b0, gi_mag};
                        mlo_next   = BW'(integ_mag);
                        neg_next   = gi_reg[DW-1] ^ integ_reg[DW-1];
                        phase_next = PH_I;
                    end
                    PH_I: begin
                        sum_next   = sum_reg + ps;
                        ma_next    = {1'b0, gd_mag};
                        mlo_next   = BW'(deriv_mag);
                        neg_next   = gd_reg[DW-1] ^ deriv_reg[DW-1];
                        phase_next = PH_D;
                    end
                    PH_D: begin
                        sum_next   = sum_reg + ps;
                        state_next = ST_DONE;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end

            ST_DONE: begin
                // load the output word once the register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (is_step) begin
                        m_out_next = ogt ? omax_reg : olt ? omin_reg : sum_sh[DW-1:0];
                        m_oc_next  = ogt || olt;
                        m_ic_next  = iclamp_reg;
                        m_zi_next  = zero_reg;
                        prev_err_next = err_reg;
                        isum_next     = integ_reg;
                        if (req_reg == REQ_EXTERNAL) begin
                            prev_sp_next = sp_reg;
                        end
                    end else begin
                        m_out_next = '0;
                        m_oc_next  = 1'b0;
                        m_ic_next  = 1'b0;
                        m_zi_next  = 1'b0;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // control and history registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0; gp_reg <= '0; gi_reg <= '0; gd_reg <= '0;
            omax_reg <= '0; omin_reg <= '0; lim_reg <= '0;
            prev_err_reg <= '0; isum_reg <= '0; prev_sp_reg <= '0;
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_INC;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            sp_reg <= sp_next; gp_reg <= gp_next; gi_reg <= gi_next; gd_reg <= gd_next;
            omax_reg <= omax_next; omin_reg <= omin_next; lim_reg <= lim_next;
            prev_err_reg <= prev_err_next; isum_reg <= isum_next;
            prev_sp_reg  <= prev_sp_next;
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        req_reg <= req_next; fbr_reg <= fbr_next; dt_reg <= dt_next;
        zero_reg <= zero_next; err_reg <= err_next; integ_reg <= integ_next;
        deriv_reg <= deriv_next; iclamp_reg <= iclamp_next; neg_reg <= neg_next;
        ma_reg <= ma_next; mhi_reg <= mhi_next; mlo_reg <= mlo_next;
        num_reg <= num_next; rem_reg <= rem_next; den_reg <= den_next;
        sum_reg <= sum_next;
        m_out_reg <= m_out_next; m_oc_reg <= m_oc_next;
        m_ic_reg <= m_ic_next; m_zi_reg <= m_zi_next;
    end

endmodule

FILE: hw/rtl/pta_checker.sv
`timescale 1ns / 1ps

module pta_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [DATA_WIDTH-1:0] m_control_out
);

    // a waiting result word stays
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_control_out))
        else $error("result word dropped or changed while stalled");

    // one word at a time: no acceptance in the cycle after one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in work");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // a result appears only after the sequencer has finished with the input side idle
    a_new_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result raised while a word is still in work");

endmodule

bind pid_trapezoid_antiwindup pta_checker #(.DATA_WIDTH(DATA_WIDTH)) u_pta_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_control_out (m_control_out)
);
